@@ src/bpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Command and status codes, register map and the control word that the
// top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package bpq_pkg;

   // Command codes carried by a request word.
   typedef enum logic [1:0] {
      CMD_STATUS  = 2'd0,
      CMD_ENQUEUE = 2'd1,
      CMD_DEQUEUE = 2'd2
   } cmd_type;

   // Status codes carried by a response word.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL_DROP  = 2'd1,
      ST_EMPTY_DEQ  = 2'd2
   } status_type;

   // Register map: one register, selected by the word index of the address.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CAPACITY = 1'b0;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Broadcast control for the cell chain.
   typedef struct packed {
      logic enq;   // insert the new entry in sorted position
      logic deq;   // shift every cell one place toward the head
   } ctrl_type;

endpackage

@@ src/bpq_cell.sv @@
// ----------------------------------------------------------------------------
// Bounded priority queue storage cell
// Holds one value and priority pair and, on a broadcast command, keeps it,
// loads the new entry, or takes the pair of a neighbor.
// ----------------------------------------------------------------------------
module bpq_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  bpq_pkg::ctrl_type            ctrl,
   input  logic signed [DATA_WIDTH-1:0] new_value,
   input  logic signed [DATA_WIDTH-1:0] new_prio,
   input  logic                         occupied,
   input  logic                         prev_before,
   input  logic signed [DATA_WIDTH-1:0] prev_value,
   input  logic signed [DATA_WIDTH-1:0] prev_prio,
   input  logic signed [DATA_WIDTH-1:0] next_value,
   input  logic signed [DATA_WIDTH-1:0] next_prio,
   output logic                         ahead,
   output logic signed [DATA_WIDTH-1:0] slot_value,
   output logic signed [DATA_WIDTH-1:0] slot_prio
);

   logic signed [DATA_WIDTH-1:0] slot_value_ff, slot_value_in;
   logic signed [DATA_WIDTH-1:0] slot_prio_ff,  slot_prio_in;

   // The new entry belongs ahead of this cell when the cell is empty or holds
   // a strictly lower priority; equal priorities stay ahead of the new entry.
   assign ahead = !occupied || (slot_prio_ff < new_prio);

   always_comb begin
      slot_value_in = slot_value_ff;
      slot_prio_in  = slot_prio_ff;
      if (ctrl.enq) begin
         if (prev_before) begin
            slot_value_in = prev_value;
            slot_prio_in  = prev_prio;
         end else if (ahead) begin
            slot_value_in = new_value;
            slot_prio_in  = new_prio;
         end
      end else if (ctrl.deq) begin
         slot_value_in = next_value;
         slot_prio_in  = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      slot_value_ff <= slot_value_in;
      slot_prio_ff  <= slot_prio_in;
   end

   assign slot_value = slot_value_ff;
   assign slot_prio  = slot_prio_ff;

endmodule

@@ src/bounded_priority_queue.sv @@
// A response word is valid in the cycle after its request word is taken.
// Throughput: one request word per cycle while no stalled response holds the
// queue; every cell compares with the new priority at once: one shift step.
// Reset clears the entry count, the response valid and sets capacity to 16;
// slot contents are not cleared and are never read beyond the entry count.
// ----------------------------------------------------------------------------
// Bounded priority queue
// Sorted shift-register queue of value and priority pairs with enqueue,
// dequeue and status commands and a capacity register.
// ----------------------------------------------------------------------------
module bounded_priority_queue #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic signed [31:0]                  req_entry_value,
   input  logic signed [31:0]                  req_entry_priority,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic signed [31:0]                  rsp_head_value,
   output logic signed [31:0]                  rsp_head_priority,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_occupancy,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bpq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bpq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bpq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > bpq_pkg::CAP_W) ? CW : bpq_pkg::CAP_W;
   localparam int AIDX = bpq_pkg::CSR_ADDR_W - 1;

   logic [bpq_pkg::CAP_W-1:0] capacity_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff;
   bpq_pkg::status_type       status_ff, status_in;

   logic                      req_take;
   logic                      full;
   logic [CMPW-1:0]           cap_ext, eff_cap;
   bpq_pkg::ctrl_type         ctrl;

   logic signed [DATA_WIDTH-1:0] new_value, new_prio;
   logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];
   logic signed [DATA_WIDTH-1:0] cell_prio  [DEPTH];
   logic [DEPTH-1:0]             cell_before;
   logic [DEPTH-1:0]             occupied;
   logic signed [63:0]           head_value_wide, head_prio_wide;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[AIDX] == bpq_pkg::REG_CAPACITY) begin
         csr_prdata[bpq_pkg::CAP_W-1:0] = capacity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bpq_pkg::CAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[AIDX] == bpq_pkg::REG_CAPACITY) begin
         capacity_ff <= csr_pwdata[bpq_pkg::CAP_W-1:0];
      end
   end

   // Capacity is clamped to the range one to DEPTH.
   assign cap_ext = CMPW'(capacity_ff);
   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMPW'(1);
      end else if (cap_ext > CMPW'(DEPTH)) begin
         eff_cap = CMPW'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full = CMPW'(count_ff) >= eff_cap;

   // ---------------------------------------------------------------- control
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      count_in  = count_ff;
      status_in = bpq_pkg::ST_OK;
      ctrl      = '0;
      if (req_take) begin
         case (req_command)
            bpq_pkg::CMD_ENQUEUE: begin
               if (full) begin
                  status_in = bpq_pkg::ST_FULL_DROP;
               end else begin
                  ctrl.enq = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            bpq_pkg::CMD_DEQUEUE: begin
               if (count_ff == '0) begin
                  status_in = bpq_pkg::ST_EMPTY_DEQ;
               end else begin
                  ctrl.deq = 1'b1;
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = bpq_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= bpq_pkg::ST_OK;
      end else begin
         count_ff <= count_in;
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
            status_ff    <= status_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- cell chain
   assign new_value = DATA_WIDTH'(req_entry_value);
   assign new_prio  = DATA_WIDTH'(req_entry_priority);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic signed [DATA_WIDTH-1:0] prev_value, prev_prio, next_value, next_prio;
      logic                         prev_before;

      assign occupied[i] = IDX < count_ff;

      if (i == 0) begin : g_head
         assign prev_before = 1'b0;
         assign prev_value  = new_value;
         assign prev_prio   = new_prio;
      end else begin : g_body
         assign prev_before = cell_before[i-1];
         assign prev_value  = cell_value[i-1];
         assign prev_prio   = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[i];
         assign next_prio  = cell_prio[i];
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_prio  = cell_prio[i+1];
      end

      bpq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (new_value),
         .new_prio    (new_prio),
         .occupied    (occupied[i]),
         .prev_before (prev_before),
         .prev_value  (prev_value),
         .prev_prio   (prev_prio),
         .next_value  (next_value),
         .next_prio   (next_prio),
         .ahead       (cell_before[i]),
         .slot_value  (cell_value[i]),
         .slot_prio   (cell_prio[i])
      );
   end

   // ---------------------------------------------------------------- response
   // The queue state is frozen while a response word is stalled, so the head
   // and count can be shown straight from the chain.
   assign head_value_wide = 64'(cell_value[0]);
   assign head_prio_wide  = 64'(cell_prio[0]);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_occupancy     = count_ff;
   assign rsp_is_empty      = count_ff == '0;
   assign rsp_is_full       = full;
   assign rsp_head_value    = rsp_is_empty ? 32'sd0 : head_value_wide[31:0];
   assign rsp_head_priority = rsp_is_empty ? 32'sd0 : head_prio_wide[31:0];

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= CMPW'(DEPTH))
      else $error("entry count exceeds depth");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      req_take && req_command == bpq_pkg::CMD_ENQUEUE && !full
      |=> count_ff == $past(count_ff) + CW'(1) && rsp_status == bpq_pkg::ST_OK)
      else $error("accepted enqueue did not add an entry");

   a_deq_shrinks: assert property (@(posedge clock) disable iff (reset)
      req_take && req_command == bpq_pkg::CMD_DEQUEUE && count_ff != '0
      |=> count_ff == $past(count_ff) - CW'(1))
      else $error("accepted dequeue did not remove an entry");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == bpq_pkg::ST_EMPTY_DEQ |-> count_ff == '0)
      else $error("dequeue on empty reported with stored entries");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> cell_prio[0] >= cell_prio[1])
      else $error("head entry is out of priority order");

endmodule

@@ verif/bounded_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// Bounded priority queue testbench
// Drives enqueue, dequeue and status commands through the request channel
// and checks every response word against a sorted-queue predictor kept in
// a scoreboard. The capacity register is changed between phases, including
// values outside the usable range and values below the current occupancy.
// Both channels see random idle and stall bursts until the closing stretch.
// ----------------------------------------------------------------------------
module bounded_priority_queue_tb;

   localparam int CAP_W = bpq_pkg::CAP_W;
   localparam int CSR_ADDR_W = bpq_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = bpq_pkg::CSR_DATA_W;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {bpq_pkg::REG_CAPACITY, 2'b00};
   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 1400;
   localparam int PHASES = 14;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [31:0] value;
      logic [31:0] prio;
   } slot_type;

   typedef struct {
      logic [1:0]       status;
      logic [31:0]      head_value;
      logic [31:0]      head_priority;
      logic [CAP_W-1:0] occupancy;
      logic             is_empty;
      logic             is_full;
   } response_type;

   class priority_queue_scoreboard;
      slot_type         slots[$];
      response_type     pending_responses[$];
      logic [CAP_W-1:0] capacity = bpq_pkg::CAP_RESET;
      int               mismatches = 0;
      int               checked = 0;
      int               full_drops = 0;
      int               empty_dequeues = 0;

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      // Out-of-range settings are clamped to 1 .. depth.
      function int usable_capacity();
         if (capacity < 1) return 1;
         if (capacity > QUEUE_DEPTH) return QUEUE_DEPTH;
         return int'(capacity);
      endfunction

      function int occupancy();
         return slots.size();
      endfunction

      function int pending();
         return pending_responses.size();
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      // Applies one accepted command and queues the response it must produce.
      function void note_command(logic [1:0] cmd, logic [31:0] v, logic [31:0] p);
         response_type r;
         slot_type     s;
         int           pos;
         int           lim;
         lim = usable_capacity();
         r.status = bpq_pkg::ST_OK;
         if (cmd == bpq_pkg::CMD_ENQUEUE) begin
            if (slots.size() >= lim) begin
               r.status = bpq_pkg::ST_FULL_DROP;
               full_drops++;
            end else begin
               // A new entry goes behind every entry of equal or higher priority.
               pos = 0;
               while (pos < slots.size() && !($signed(slots[pos].prio) < $signed(p)))
                  pos++;
               s.value = v;
               s.prio = p;
               slots.insert(pos, s);
            end
         end else if (cmd == bpq_pkg::CMD_DEQUEUE) begin
            if (slots.size() == 0) begin
               r.status = bpq_pkg::ST_EMPTY_DEQ;
               empty_dequeues++;
            end else begin
               void'(slots.pop_front());
            end
         end
         r.head_value = slots.size() != 0 ? slots[0].value : 32'd0;
         r.head_priority = slots.size() != 0 ? slots[0].prio : 32'd0;
         r.occupancy = CAP_W'(slots.size());
         r.is_empty = slots.size() == 0;
         r.is_full = slots.size() >= lim;
         pending_responses.push_back(r);
      endfunction

      function void check_response(response_type got);
         response_type exp;
         bit           bad;
         checked++;
         if (pending_responses.size() == 0) begin
            flag($sformatf("response word with nothing expected: st=%0d hv=%h hp=%h occ=%0d",
                           got.status, got.head_value, got.head_priority, got.occupancy));
            return;
         end
         exp = pending_responses.pop_front();
         bad = (got.status !== exp.status) || (got.head_value !== exp.head_value) ||
               (got.head_priority !== exp.head_priority) ||
               (got.occupancy !== exp.occupancy) || (got.is_empty !== exp.is_empty) ||
               (got.is_full !== exp.is_full);
         if (bad)
            flag($sformatf({"word %0d expected st=%0d hv=%h hp=%h occ=%0d e=%0b f=%0b, ",
                            "got st=%0d hv=%h hp=%h occ=%0d e=%0b f=%0b"}, checked,
                           exp.status, exp.head_value, exp.head_priority, exp.occupancy,
                           exp.is_empty, exp.is_full, got.status, got.head_value,
                           got.head_priority, got.occupancy, got.is_empty, got.is_full));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_command;
   logic signed [31:0]    req_entry_value;
   logic signed [31:0]    req_entry_priority;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_status;
   logic signed [31:0]    rsp_head_value;
   logic signed [31:0]    rsp_head_priority;
   logic [CAP_W-1:0]      rsp_occupancy;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   priority_queue_scoreboard sb = new();
   bit quiet = 1'b0;
   int words_sent = 0;
   int cycle_count = 0;

   bounded_priority_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_entry_value(req_entry_value), .req_entry_priority(req_entry_priority),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_head_value(rsp_head_value), .rsp_head_priority(rsp_head_priority),
      .rsp_occupancy(rsp_occupancy), .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding.",
                  cycle_count, sb.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      response_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = rsp_status;
         got.head_value = rsp_head_value;
         got.head_priority = rsp_head_priority;
         got.occupancy = rsp_occupancy;
         got.is_empty = rsp_is_empty;
         got.is_full = rsp_is_full;
         sb.check_response(got);
      end
   end

   // Receiver back-pressure in random bursts; none in the closing stretch.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   // Mostly a narrow band so that equal priorities are common.
   function automatic logic [31:0] pick_priority();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 6) return $urandom_range(0, 6) - 3;
      if (mode < 9) return $urandom;
      return pick_extreme();
   endfunction

   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 9) == 0) return pick_extreme();
      return $urandom;
   endfunction

   // Valid stays high from one word to the next unless a gap is inserted.
   task automatic send_word(input logic [1:0] cmd, input logic [31:0] v,
                            input logic [31:0] p);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_value <= v;
      req_entry_priority <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_command(cmd, v, p);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= CAPACITY_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Capacity only changes with the queue idle; the value is read back.
   task automatic set_capacity(input logic [31:0] cap);
      logic [31:0] rd;
      drain();
      csr_access(1'b1, cap, rd);
      sb.set_capacity(cap[CAP_W-1:0]);
      csr_access(1'b0, 32'd0, rd);
      if (rd[CAP_W-1:0] !== cap[CAP_W-1:0])
         sb.flag($sformatf("capacity read back %0d, written %0d",
                           rd[CAP_W-1:0], cap[CAP_W-1:0]));
   endtask

   task automatic run_directed();
      send_word(bpq_pkg::CMD_STATUS, 32'hdead_beef, 32'h1234_5678);
      send_word(bpq_pkg::CMD_DEQUEUE, 32'h0, 32'h0);
      send_word(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
      send_word(bpq_pkg::CMD_ENQUEUE, 32'h7fff_ffff, 32'h8000_0000);
      send_word(bpq_pkg::CMD_ENQUEUE, 32'h8000_0000, 32'h7fff_ffff);
      // Three entries of equal priority must leave in arrival order.
      send_word(bpq_pkg::CMD_ENQUEUE, 32'd1, 32'd0);
      send_word(bpq_pkg::CMD_ENQUEUE, 32'd2, 32'd0);
      send_word(bpq_pkg::CMD_ENQUEUE, 32'd3, 32'd0);
      send_word(bpq_pkg::CMD_ENQUEUE, 32'hffff_ffff, 32'hffff_ffff);
      send_word(bpq_pkg::CMD_STATUS, 32'h0, 32'h0);
      repeat (7) send_word(bpq_pkg::CMD_DEQUEUE, 32'h5555_5555, 32'haaaa_aaaa);
      set_capacity(32'd1);
      send_word(bpq_pkg::CMD_ENQUEUE, 32'd42, 32'd7);
      send_word(bpq_pkg::CMD_ENQUEUE, 32'd43, 32'd9);
      send_word(CMD_UNUSED, 32'd0, 32'd0);
      send_word(bpq_pkg::CMD_DEQUEUE, 32'd0, 32'd0);
   endtask

   initial begin
      logic [31:0] fixed_caps[6];
      logic [31:0] cap;
      logic [1:0]  cmd;
      bit          filling;
      int          run_left;
      int          pick;
      int          sent_random;

      fixed_caps = '{32'd0, 32'd31, 32'd3, 32'd16, 32'd2, 32'd1};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= bpq_pkg::CMD_STATUS;
      req_entry_value <= '0;
      req_entry_priority <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      filling = 1'b1;
      run_left = 0;
      sent_random = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         cap = ph < 6 ? fixed_caps[ph] : $urandom_range(0, 31);
         // Fill the queue first so the lower limit lands below occupancy.
         if (ph == 2)
            while (sb.occupancy() < 10)
               send_word(bpq_pkg::CMD_ENQUEUE, pick_value(), pick_priority());
         set_capacity(cap);
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            if (sent_random >= RANDOM_ITEMS * 85 / 100) quiet = 1'b1;
            // Alternate runs of mostly enqueues and mostly dequeues so the
            // queue keeps hitting both the full and the empty boundary.
            if (run_left == 0) begin
               filling = !filling;
               run_left = $urandom_range(1, sb.usable_capacity() + 4);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick < 8) cmd = bpq_pkg::CMD_STATUS;
            else if (pick < 12) cmd = CMD_UNUSED;
            else if (pick < 22) cmd = filling ? bpq_pkg::CMD_DEQUEUE : bpq_pkg::CMD_ENQUEUE;
            else cmd = filling ? bpq_pkg::CMD_ENQUEUE : bpq_pkg::CMD_DEQUEUE;
            send_word(cmd, pick_value(), pick_priority());
            sent_random++;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d command words over %0d capacity settings; %0d responses checked.",
               words_sent, PHASES + 2, sb.checked);
      $display("Saw %0d enqueues dropped while full and %0d dequeues on empty; %0d mismatches.",
               sb.full_drops, sb.empty_dequeues, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
